// ===== hdl/rgbwl_pkg.sv =====
// rgbwl_pkg: shared types, constants and lookup tables of the rgbw light effect sequencer
package rgbwl_pkg;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned TIMER_W = 9;

	localparam logic [LEVEL_W-1:0] FADE_TOP = 8'd255;
	localparam logic [LEVEL_W-1:0] FULL_ON  = 8'd255;

	localparam logic [3:0] PROG_STATIC_LAST = 4'd6;
	localparam logic [3:0] PROG_STROBE      = 4'd7;
	localparam logic [3:0] PROG_RAMP        = 4'd8;
	localparam logic [3:0] PROG_CROSS       = 4'd9;
	localparam logic [3:0] DEPTH_MAX        = 4'd9;

	localparam logic [3:0] PHASE_WRAP      = 4'd14;
	localparam logic [3:0] PHASE_LAST      = 4'd13;
	localparam logic [3:0] CROSS_WRAP      = 4'd8;
	localparam logic [3:0] CROSS_LAST      = 4'd7;

	// channel masks, bit 0 red, 1 green, 2 blue, 3 white
	localparam logic [3:0] M_R = 4'b0001;
	localparam logic [3:0] M_G = 4'b0010;
	localparam logic [3:0] M_B = 4'b0100;
	localparam logic [3:0] M_W = 4'b1000;

	typedef logic [3:0][LEVEL_W-1:0] levels_t;

	typedef struct packed {
		logic       enabled;
		logic [3:0] program_req;
		logic [3:0] depth;
		logic       tick;
	} in_item_t;

	typedef struct packed {
		levels_t levels;
		logic    levels_changed;
	} result_t;

	function automatic logic [7:0] depth_level(input logic [3:0] d);
		case (d)
			4'd0:    return 8'd25;
			4'd1:    return 8'd25;
			4'd2:    return 8'd44;
			4'd3:    return 8'd64;
			4'd4:    return 8'd83;
			4'd5:    return 8'd102;
			4'd6:    return 8'd134;
			4'd7:    return 8'd166;
			4'd8:    return 8'd217;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [TIMER_W-1:0] fade_speed(input logic [3:0] d);
		case (d)
			4'd0:    return 9'd20;
			4'd1:    return 9'd20;
			4'd2:    return 9'd15;
			4'd3:    return 9'd10;
			4'd4:    return 9'd6;
			4'd5:    return 9'd5;
			4'd6:    return 9'd4;
			4'd7:    return 9'd3;
			4'd8:    return 9'd2;
			default: return 9'd1;
		endcase
	endfunction

	// half of the strobe period table
	function automatic logic [TIMER_W-1:0] strobe_hold(input logic [3:0] d);
		case (d)
			4'd0:    return 9'd350;
			4'd1:    return 9'd350;
			4'd2:    return 9'd300;
			4'd3:    return 9'd250;
			4'd4:    return 9'd200;
			4'd5:    return 9'd175;
			4'd6:    return 9'd150;
			4'd7:    return 9'd125;
			4'd8:    return 9'd100;
			default: return 9'd50;
		endcase
	endfunction

	function automatic logic [3:0] strobe_count(input logic [3:0] d);
		case (d)
			4'd0:    return 4'd4;
			4'd1:    return 4'd4;
			4'd2:    return 4'd5;
			4'd3:    return 4'd6;
			4'd4:    return 4'd6;
			4'd5:    return 4'd7;
			4'd6:    return 4'd7;
			4'd7:    return 4'd8;
			4'd8:    return 4'd8;
			default: return 4'd9;
		endcase
	endfunction

	// red, green, blue, purple, yellow, cyan, then white
	function automatic logic [3:0] colour_mask(input logic [2:0] k, input logic white_mode);
		case (k)
			3'd0:    return M_R;
			3'd1:    return M_G;
			3'd2:    return M_B;
			3'd3:    return M_R | M_B;
			3'd4:    return M_R | M_G;
			3'd5:    return M_G | M_B;
			default: return white_mode ? M_W : (M_R | M_G | M_B);
		endcase
	endfunction

	function automatic levels_t apply_mask(input logic [3:0] mask, input logic [7:0] v);
		levels_t l;
		for (int i = 0; i < 4; i++) begin
			l[i] = mask[i] ? v : 8'd0;
		end
		return l;
	endfunction

	function automatic levels_t mk_levels(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] w);
		levels_t l;
		l[0] = r;
		l[1] = g;
		l[2] = b;
		l[3] = w;
		return l;
	endfunction

endpackage

// ===== hdl/rgbwl_if.sv =====
// rgbwl_if: request and level channel interfaces with valid/ready handshake
interface rgbwl_req_if;
	logic       valid;
	logic       ready;
	logic       enabled;
	logic [3:0] program_req;
	logic [3:0] depth;
	logic       tick;

	modport source (output valid, enabled, program_req, depth, tick, input ready);
	modport sink (input valid, enabled, program_req, depth, tick, output ready);
endinterface

interface rgbwl_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	logic [7:0] white_level;
	logic       levels_changed;

	modport source (output valid, red_level, green_level, blue_level, white_level,
		levels_changed, input ready);
	modport sink (input valid, red_level, green_level, blue_level, white_level,
		levels_changed, output ready);
endinterface

// ===== hdl/rgbw_light_effect_sequencer.sv =====
// rgbw_light_effect_sequencer: top level with input stage, effect core and result register
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    enabled, program_req, depth, tick
//  rsp      out  valid/ready    red/green/blue/white_level, levels_changed
//  cfg      in   cfg_we         cfg_wdata (white_mode)
//
// one item per cycle unless rsp stalls; a result passes the input and result registers
// the input register feeds the core, whose state updates as the result is registered
// a stalled result register holds the core and the input stage; req stays ready while
// the input stage is empty or moving
// reset clears the effect state and white_mode; restart is pending after reset
module rgbw_light_effect_sequencer import rgbwl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	rgbwl_req_if.sink   req,
	rgbwl_rsp_if.source rsp,
	input  logic   cfg_we,
	input  logic   cfg_wdata
);

	in_item_t item_s1;
	logic     valid_s1;
	result_t  res_q;
	result_t  res_d;
	logic     res_valid_q;
	logic     white_mode_q;
	logic     adv;
	logic     step;

	assign adv       = !res_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_mode_q <= 1'b0;
		end else if (cfg_we) begin
			white_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.enabled     <= req.enabled;
			item_s1.program_req <= req.program_req;
			item_s1.depth       <= req.depth;
			item_s1.tick        <= req.tick;
		end
	end

	rgbwl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.white_mode (white_mode_q),
		.result     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid          = res_valid_q;
	assign rsp.red_level      = res_q.levels[0];
	assign rsp.green_level    = res_q.levels[1];
	assign rsp.blue_level     = res_q.levels[2];
	assign rsp.white_level    = res_q.levels[3];
	assign rsp.levels_changed = res_q.levels_changed;

`ifndef SYNTHESIS
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_valid_q)
		else $error("stepped item did not reach the result register");

	a_disabled_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item_s1.enabled |=> !res_q.levels_changed)
		else $error("disabled item wrote the levels");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost an item under stall");
`endif

endmodule

// ===== hdl/rgbwl_core.sv =====
// rgbwl_core: effect state registers and the one-step next-state logic
module rgbwl_core import rgbwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	input  logic     white_mode,
	output result_t  result
);

	logic [3:0]         last_prog_q, last_prog_d;
	logic [3:0]         last_dep_q, last_dep_d;
	logic               rp_q, rp_d;
	logic [3:0]         ph_q, ph_d;
	logic [TIMER_W-1:0] ht_q, ht_d;
	logic [7:0]         fade_q, fade_d;
	logic [3:0]         fl_q, fl_d;
	levels_t            lvl_q, lvl_d;
	logic               wrote;
	logic               prog_ok;
	logic [3:0]         mask;
	logic [7:0]         f, m, x;

	assign prog_ok = (item.program_req != 4'd0) && (item.program_req <= PROG_CROSS)
		&& (item.depth <= DEPTH_MAX);

	always_comb begin
		last_prog_d = last_prog_q;
		last_dep_d  = last_dep_q;
		rp_d        = rp_q;
		ph_d        = ph_q;
		ht_d        = ht_q;
		fade_d      = fade_q;
		fl_d        = fl_q;
		lvl_d       = lvl_q;
		wrote       = 1'b0;
		mask        = colour_mask(ph_q[3:1], white_mode);
		f           = fade_q;
		m           = FADE_TOP - fade_q;
		x           = fade_q;

		if (item.tick && (ht_q != '0))
			ht_d = ht_q - TIMER_W'(1);

		if (item.enabled) begin
			if ((item.program_req != last_prog_q) || (item.depth != last_dep_q)) begin
				last_prog_d = item.program_req;
				last_dep_d  = item.depth;
				rp_d        = 1'b1;
				fade_d      = 8'd0;
			end
			if (prog_ok) begin
				priority if (item.program_req <= PROG_STATIC_LAST) begin
					if (rp_d) begin
						rp_d  = 1'b0;
						lvl_d = apply_mask(colour_mask(3'(item.program_req - 4'd1), white_mode),
							depth_level(item.depth));
						wrote = 1'b1;
					end
				end else if (item.program_req == PROG_STROBE) begin
					if (rp_d) begin
						rp_d = 1'b0;
						ph_d = 4'd0;
						ht_d = '0;
						fl_d = strobe_count(item.depth);
					end
					if (ph_d >= PHASE_WRAP) begin
						ph_d = 4'd0;
					end else if (ht_d == '0) begin
						ht_d  = strobe_hold(item.depth);
						wrote = 1'b1;
						if (!ph_d[0]) begin
							lvl_d = apply_mask(colour_mask(ph_d[3:1], white_mode), FULL_ON);
							ph_d  = ph_d + 4'd1;
						end else begin
							lvl_d = '0;
							if (fl_d > 4'd1) begin
								fl_d = fl_d - 4'd1;
								ph_d = ph_d - 4'd1;
							end else begin
								fl_d = strobe_count(item.depth);
								ph_d = (ph_d >= PHASE_LAST) ? 4'd0 : ph_d + 4'd1;
							end
						end
					end
				end else if (item.program_req == PROG_RAMP) begin
					if (rp_d) begin
						rp_d = 1'b0;
						ph_d = 4'd0;
						ht_d = '0;
					end
					if (ph_d >= PHASE_WRAP) begin
						ph_d = 4'd0;
					end else if (ht_d == '0) begin
						mask = colour_mask(ph_d[3:1], white_mode);
						if (!ph_d[0]) begin
							if (fade_d < FADE_TOP) begin
								lvl_d  = apply_mask(mask, fade_d);
								wrote  = 1'b1;
								fade_d = fade_d + 8'd1;
							end else begin
								ph_d = ph_d + 4'd1;
							end
						end else begin
							if (fade_d != 8'd0) begin
								lvl_d  = apply_mask(mask, fade_d);
								wrote  = 1'b1;
								fade_d = fade_d - 8'd1;
							end else begin
								ph_d = (ph_d >= PHASE_LAST) ? 4'd0 : ph_d + 4'd1;
							end
						end
						ht_d = fade_speed(item.depth);
					end
				end else begin
					if (rp_d || (ph_d >= CROSS_WRAP)) begin
						rp_d   = 1'b0;
						ph_d   = 4'd0;
						ht_d   = '0;
						fade_d = 8'd0;
						lvl_d  = '0;
						wrote  = 1'b1;
					end else if (ht_d == '0) begin
						ht_d = fade_speed(item.depth);
						if (fade_d >= FADE_TOP) begin
							ph_d   = (ph_d >= CROSS_LAST) ? 4'd1 : ph_d + 4'd1;
							fade_d = 8'd0;
						end else begin
							f     = fade_d;
							m     = FADE_TOP - fade_d;
							x     = (f > m) ? f : m;
							wrote = 1'b1;
							unique case (ph_d[2:0])
								3'd0: lvl_d = apply_mask(colour_mask(3'd6, white_mode), f);
								3'd1: lvl_d = white_mode ? mk_levels(f, 8'd0, 8'd0, m)
									: mk_levels(x, m, m, 8'd0);
								3'd2: lvl_d = mk_levels(m, f, 8'd0, 8'd0);
								3'd3: lvl_d = mk_levels(8'd0, m, f, 8'd0);
								3'd4: lvl_d = mk_levels(f, 8'd0, x, 8'd0);
								3'd5: lvl_d = mk_levels(x, f, m, 8'd0);
								3'd6: lvl_d = mk_levels(m, x, f, 8'd0);
								3'd7: lvl_d = white_mode ? mk_levels(8'd0, m, m, f)
									: mk_levels(f, x, x, 8'd0);
							endcase
							fade_d = f + 8'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_prog_q <= '0;
			last_dep_q  <= '0;
			rp_q        <= 1'b1;
			ph_q        <= '0;
			ht_q        <= '0;
			fade_q      <= '0;
			fl_q        <= '0;
			lvl_q       <= '0;
		end else if (step) begin
			last_prog_q <= last_prog_d;
			last_dep_q  <= last_dep_d;
			rp_q        <= rp_d;
			ph_q        <= ph_d;
			ht_q        <= ht_d;
			fade_q      <= fade_d;
			fl_q        <= fl_d;
			lvl_q       <= lvl_d;
		end
	end

	assign result.levels         = lvl_d;
	assign result.levels_changed = wrote;

endmodule

// ===== tb/rgbwl_level_checker.sv =====
// rgbwl_level_checker: predicts the channel levels of each accepted request and checks the results
module rgbwl_level_checker import rgbwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rgbwl_req_if req,
	rgbwl_rsp_if rsp,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   fail_count,
	output int   pending
);

	localparam logic [3:0] PROG_NONE = 4'd0;
	localparam int         REPORT_MAX = 100;

	logic [7:0]  level_of_depth [10] = '{25, 25, 44, 64, 83, 102, 134, 166, 217, 255};
	logic [8:0]  fade_hold [10] = '{20, 20, 15, 10, 6, 5, 4, 3, 2, 1};
	logic [15:0] strobe_period [10] = '{700, 700, 600, 500, 400, 350, 300, 250, 200, 100};
	logic [3:0]  flash_count [10] = '{4, 4, 5, 6, 6, 7, 7, 8, 8, 9};
	logic [3:0]  palette [6] = '{M_R, M_G, M_B, M_R | M_B, M_R | M_G, M_G | M_B};

	logic       white_sel;
	logic [3:0] prev_prog;
	logic [3:0] prev_depth;
	logic       restart;
	logic [3:0] phase;
	logic [8:0] hold;
	logic [7:0] fade;
	logic [3:0] flashes;
	levels_t    lv;
	logic       wrote;

	result_t    expected_q [$];
	int         errs = 0;

	function automatic void set_levels(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] w);
		lv[0] = r;
		lv[1] = g;
		lv[2] = b;
		lv[3] = w;
		wrote = 1'b1;
	endfunction

	function automatic void fill_mask(input logic [3:0] mask, input logic [7:0] v);
		set_levels(mask[0] ? v : 8'd0, mask[1] ? v : 8'd0,
			mask[2] ? v : 8'd0, mask[3] ? v : 8'd0);
	endfunction

	function automatic logic [3:0] colour_of(input logic [2:0] k);
		if (k < 3'd6)
			return palette[k];
		return white_sel ? M_W : (M_R | M_G | M_B);
	endfunction

	function automatic void strobe_step(input logic [3:0] d);
		if (restart) begin
			restart = 1'b0;
			phase = 4'd0;
			hold = 9'd0;
			flashes = flash_count[d];
		end
		if (phase >= PHASE_WRAP) begin
			phase = 4'd0;
			return;
		end
		if (hold != 9'd0)
			return;
		hold = 9'(strobe_period[d] >> 1);
		if (!phase[0]) begin
			fill_mask(colour_of(phase[3:1]), FULL_ON);
			phase = phase + 4'd1;
		end else begin
			set_levels(8'd0, 8'd0, 8'd0, 8'd0);
			if (flashes > 4'd1) begin
				flashes = flashes - 4'd1;
				phase = phase - 4'd1;
			end else begin
				flashes = flash_count[d];
				phase = (phase >= PHASE_LAST) ? 4'd0 : phase + 4'd1;
			end
		end
	endfunction

	function automatic void ramp_step(input logic [3:0] d);
		logic [3:0] mask;
		if (restart) begin
			restart = 1'b0;
			phase = 4'd0;
			hold = 9'd0;
		end
		if (phase >= PHASE_WRAP) begin
			phase = 4'd0;
			return;
		end
		if (hold != 9'd0)
			return;
		mask = colour_of(phase[3:1]);
		if (!phase[0]) begin
			if (fade < FADE_TOP) begin
				fill_mask(mask, fade);
				fade = fade + 8'd1;
			end else begin
				phase = phase + 4'd1;
			end
		end else begin
			if (fade != 8'd0) begin
				fill_mask(mask, fade);
				fade = fade - 8'd1;
			end else begin
				phase = (phase >= PHASE_LAST) ? 4'd0 : phase + 4'd1;
			end
		end
		hold = fade_hold[d];
	endfunction

	function automatic void cross_step(input logic [3:0] d);
		logic [7:0] f;
		logic [7:0] m;
		logic [7:0] x;
		if (restart || phase >= CROSS_WRAP) begin
			restart = 1'b0;
			phase = 4'd0;
			hold = 9'd0;
			fade = 8'd0;
			set_levels(8'd0, 8'd0, 8'd0, 8'd0);
			return;
		end
		if (hold != 9'd0)
			return;
		hold = fade_hold[d];
		if (fade >= FADE_TOP) begin
			phase = (phase >= CROSS_LAST) ? 4'd1 : phase + 4'd1;
			fade = 8'd0;
			return;
		end
		f = fade;
		m = FADE_TOP - f;
		x = (f > m) ? f : m;
		case (phase)
			4'd0: fill_mask(colour_of(3'd6), f);
			4'd1: begin
				if (white_sel)
					set_levels(f, 8'd0, 8'd0, m);
				else
					set_levels(x, m, m, 8'd0);
			end
			4'd2: set_levels(m, f, 8'd0, 8'd0);
			4'd3: set_levels(8'd0, m, f, 8'd0);
			4'd4: set_levels(f, 8'd0, x, 8'd0);
			4'd5: set_levels(x, f, m, 8'd0);
			4'd6: set_levels(m, x, f, 8'd0);
			default: begin
				if (white_sel)
					set_levels(8'd0, m, m, f);
				else
					set_levels(f, x, x, 8'd0);
			end
		endcase
		fade = f + 8'd1;
	endfunction

	function automatic result_t step_effect(input in_item_t it);
		result_t r;
		wrote = 1'b0;
		if (it.tick && hold != 9'd0)
			hold = hold - 9'd1;
		if (it.enabled) begin
			if (it.program_req != prev_prog || it.depth != prev_depth) begin
				prev_prog = it.program_req;
				prev_depth = it.depth;
				restart = 1'b1;
				fade = 8'd0;
			end
			if (it.program_req != PROG_NONE && it.program_req <= PROG_CROSS
					&& it.depth <= DEPTH_MAX) begin
				if (it.program_req <= PROG_STATIC_LAST) begin
					if (restart) begin
						restart = 1'b0;
						fill_mask(palette[it.program_req - 4'd1], level_of_depth[it.depth]);
					end
				end else if (it.program_req == PROG_STROBE) begin
					strobe_step(it.depth);
				end else if (it.program_req == PROG_RAMP) begin
					ramp_step(it.depth);
				end else begin
					cross_step(it.depth);
				end
			end
		end
		r.levels = lv;
		r.levels_changed = wrote;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			if (errs < REPORT_MAX)
				$display("%0t %s expected %0d actual %0d", $time, what, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_item_t taken;
		result_t  want;
		if (!arst_n) begin
			white_sel = 1'b0;
			prev_prog = 4'd0;
			prev_depth = 4'd0;
			restart = 1'b1;
			phase = 4'd0;
			hold = 9'd0;
			fade = 8'd0;
			flashes = 4'd0;
			lv = '0;
			wrote = 1'b0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				white_sel = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					if (errs < REPORT_MAX)
						$display("%0t unexpected item: levels %0d %0d %0d %0d changed %0d",
							$time, rsp.red_level, rsp.green_level, rsp.blue_level,
							rsp.white_level, rsp.levels_changed);
					errs++;
				end else begin
					want = expected_q.pop_front();
					check_field("red_level", want.levels[0], rsp.red_level);
					check_field("green_level", want.levels[1], rsp.green_level);
					check_field("blue_level", want.levels[2], rsp.blue_level);
					check_field("white_level", want.levels[3], rsp.white_level);
					check_field("levels_changed", 8'(want.levels_changed),
						8'(rsp.levels_changed));
				end
			end
			if (req.valid && req.ready) begin
				taken.enabled = req.enabled;
				taken.program_req = req.program_req;
				taken.depth = req.depth;
				taken.tick = req.tick;
				expected_q.push_back(step_effect(taken));
			end
			pending <= expected_q.size();
		end
		fail_count <= errs;
	end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus, flow control and verdict for the rgbw light effect sequencer
module tb_top;
	import rgbwl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   pending;
	int   active_items = 0;
	int   burst_left = 0;
	int   cycles = 0;

	rgbwl_req_if req();
	rgbwl_rsp_if rsp();

	rgbw_light_effect_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rgbwl_level_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t mk_item(input logic en, input logic [3:0] prog,
			input logic [3:0] dep, input logic tk);
		in_item_t it;
		it.enabled = en;
		it.program_req = prog;
		it.depth = dep;
		it.tick = tk;
		return it;
	endfunction

	task automatic push_request(input in_item_t it);
		int gap;
		if (burst_left != 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = gap_len();
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(20, 80);
		end
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.enabled <= it.enabled;
		req.program_req <= it.program_req;
		req.depth <= it.depth;
		req.tick <= it.tick;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (it.enabled)
			active_items++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_white_mode(input logic v);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic play_run(input logic [3:0] prog, input logic [3:0] dep, input int len);
		repeat (len)
			push_request(mk_item($urandom_range(0, 24) != 0, prog, dep,
				$urandom_range(0, 9) != 0));
	endtask

	task automatic run_random(input int target);
		int         stop_at;
		int         r;
		int         len;
		logic [3:0] prog;
		logic [3:0] dep;
		logic [9:0] raw;
		stop_at = active_items + target;
		while (active_items < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				// noise: every field random
				repeat ($urandom_range(1, 6)) begin
					raw = 10'($urandom);
					push_request(raw);
				end
			end else begin
				r = $urandom_range(0, 9);
				if (r < 3)
					prog = 4'($urandom_range(1, 6));
				else if (r < 5)
					prog = PROG_STROBE;
				else if (r < 7)
					prog = PROG_RAMP;
				else
					prog = PROG_CROSS;
				dep = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 9))
					: 4'($urandom_range(7, 9));
				r = $urandom_range(0, 19);
				if (r < 12)
					len = $urandom_range(1, 8);
				else if (r < 18)
					len = $urandom_range(9, 60);
				else
					len = $urandom_range(150, 400);
				if (len > stop_at - active_items)
					len = stop_at - active_items;
				play_run(prog, dep, len);
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off once traffic is flowing
	initial begin
		int  busy;
		int  free;
		bit  pressed;
		busy = 0;
		free = 0;
		pressed = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressed && active_items >= 60) begin
				pressed = 1'b1;
				busy = 80;
			end else if (busy == 0 && free == 0) begin
				busy = gap_len();
				free = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
					: $urandom_range(1, 12);
			end
			if (busy != 0) begin
				busy--;
				rsp.ready <= 1'b0;
			end else begin
				free--;
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req.valid <= 1'b0;
		req.enabled <= 1'b0;
		req.program_req <= 4'd0;
		req.depth <= 4'd0;
		req.tick <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items, white made from red green blue
		push_request(mk_item(1'b0, PROG_CROSS, 4'd0, 1'b1));
		push_request(mk_item(1'b1, 4'h0, 4'h0, 1'b0));
		push_request(mk_item(1'b1, 4'hF, 4'hF, 1'b1));
		push_request(mk_item(1'b1, PROG_RAMP, 4'd10, 1'b0));
		for (int p = 1; p <= PROG_STATIC_LAST; p++)
			push_request(mk_item(1'b1, 4'(p), 4'(p + 3), 1'b1));
		push_request(mk_item(1'b1, PROG_STATIC_LAST, DEPTH_MAX, 1'b1));
		push_request(mk_item(1'b1, PROG_STROBE, DEPTH_MAX, 1'b1));
		push_request(mk_item(1'b1, PROG_STROBE, DEPTH_MAX, 1'b1));
		push_request(mk_item(1'b1, PROG_RAMP, 4'd0, 1'b0));
		push_request(mk_item(1'b1, PROG_RAMP, 4'd0, 1'b1));
		repeat (3) push_request(mk_item(1'b1, PROG_CROSS, DEPTH_MAX, 1'b1));
		push_request(mk_item(1'b0, PROG_CROSS, DEPTH_MAX, 1'b1));
		push_request(mk_item(1'b1, PROG_CROSS, 4'hF, 1'b1));
		push_request(mk_item(1'b1, PROG_CROSS, DEPTH_MAX, 1'b1));

		// dedicated white channel, long cross-fade into the second colour pair
		write_white_mode(1'b1);
		play_run(PROG_CROSS, DEPTH_MAX, 330);
		run_random(100);

		write_white_mode(1'b0);
		play_run(PROG_CROSS, DEPTH_MAX, 330);
		run_random(100);

		write_white_mode(1'b1);
		run_random(120);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rgbwl_pkg.sv
hdl/rgbwl_if.sv
hdl/rgbwl_core.sv
hdl/rgbw_light_effect_sequencer.sv
tb/rgbwl_level_checker.sv
tb/tb_top.sv
